FILE: rtl/tcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcc_pkg: shared types and constants for the thermal conveyor controller
// Register indexes, override mask bit positions, sensor and heater counts,
// and the signed maximum helper used by the frame path.
// ----------------------------------------------------------------------------
package tcc_pkg;

   // sensor and heater population
   localparam int NUM_SENSORS = 10;
   localparam int NUM_HEATERS = 3;
   localparam int MAX_SENSORS = 10;
   localparam int MAX_HEATERS = 3;

   // configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   typedef logic signed [15:0]     temp_type;
   typedef logic [31:0]            tick_count_type;

   localparam csr_index_type CSR_MAX_TEMP      = 3'd0;
   localparam csr_index_type CSR_COOLING_TEMP  = 3'd1;
   localparam csr_index_type CSR_RUN_SPEED     = 3'd2;
   localparam csr_index_type CSR_MANUAL_MASK   = 3'd3;
   localparam csr_index_type CSR_START_PERIOD  = 3'd4;
   localparam csr_index_type CSR_HEAT_ON       = 3'd5;
   localparam csr_index_type CSR_HEAT_OFF      = 3'd6;

   // manual override mask bit positions
   localparam int MAN_CONVEYOR_BIT = 0;
   localparam int MAN_HEATER0_BIT  = 1;
   localparam int MAN_COOLER_BIT   = 4;

   // item operation codes
   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_FRAME = 1'b1;

   function automatic temp_type smax(input temp_type a, input temp_type b);
      smax = (a > b) ? a : b;
   endfunction

endpackage

FILE: rtl/thermal_conveyor_controller_unit.sv
`timescale 1ns / 1ps
// A result is registered and appears in the cycle after its item is accepted.
// Throughput: one item per cycle; the single result register frees in the
// same cycle it is taken, so req_ready follows rsp_ready when it is full.
// Reset (synchronous, active high) clears all config registers to zero, sets
// the start flag and heating window, and zeroes counters and held outputs.
// ----------------------------------------------------------------------------
// thermal_conveyor_controller_unit: tick/frame driven conveyor, heater and
// cooler controller
// Ticks advance the start-up and heater duty-cycle counters; frames take the
// signed maximum of the sensor readings and update non-overridden outputs.
// ----------------------------------------------------------------------------
module thermal_conveyor_controller_unit (
   input  logic                              clock,
   input  logic                              reset,
   // configuration port
   input  logic                              csr_wr_en,
   input  tcc_pkg::csr_index_type            csr_index,
   input  logic [tcc_pkg::CSR_DATA_W-1:0]    csr_wdata,
   // input item channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_operation,
   input  logic signed [15:0]                req_temp_1,
   input  logic signed [15:0]                req_temp_2,
   input  logic signed [15:0]                req_temp_3,
   input  logic signed [15:0]                req_temp_4,
   input  logic signed [15:0]                req_temp_5,
   input  logic signed [15:0]                req_temp_6,
   input  logic signed [15:0]                req_temp_7,
   input  logic signed [15:0]                req_temp_8,
   input  logic signed [15:0]                req_temp_9,
   input  logic signed [15:0]                req_temp_10,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [7:0]                        rsp_conveyor_speed_out,
   output logic [2:0]                        rsp_heater_bits,
   output logic                              rsp_cooler_on,
   output logic                              rsp_heating_window_on,
   output logic                              rsp_start_phase_on
);

   // configuration registers
   tcc_pkg::temp_type       max_temp_ff;
   tcc_pkg::temp_type       cooling_temp_ff;
   logic [7:0]              run_speed_ff;
   logic [4:0]              manual_mask_ff;
   tcc_pkg::tick_count_type start_period_ff;
   tcc_pkg::tick_count_type heat_on_ff;
   tcc_pkg::tick_count_type heat_off_ff;

   // controller state
   tcc_pkg::tick_count_type start_elapsed_ff, start_elapsed_in;
   tcc_pkg::tick_count_type phase_elapsed_ff, phase_elapsed_in;
   logic                    in_start_ff, in_start_in;
   logic                    window_ff, window_in;
   logic [7:0]              speed_ff, speed_in;
   logic [2:0]              heater_ff, heater_in;
   logic                    cooler_ff, cooler_in;

   // result register
   logic                    rsp_valid_ff;
   logic [7:0]              rsp_speed_ff;
   logic [2:0]              rsp_heater_ff;
   logic                    rsp_cooler_ff;
   logic                    rsp_window_ff;
   logic                    rsp_start_ff;

   logic                    accept;
   tcc_pkg::tick_count_type start_inc;
   tcc_pkg::tick_count_type phase_inc;
   tcc_pkg::temp_type       temps [tcc_pkg::MAX_SENSORS];
   tcc_pkg::temp_type       lvl1  [5];
   tcc_pkg::temp_type       lvl2a, lvl2b, lvl3, frame_max;
   logic                    over_temp;

   // the result slot frees whenever the held item is taken
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // configuration writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         max_temp_ff     <= '0;
         cooling_temp_ff <= '0;
         run_speed_ff    <= '0;
         manual_mask_ff  <= '0;
         start_period_ff <= '0;
         heat_on_ff      <= '0;
         heat_off_ff     <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            tcc_pkg::CSR_MAX_TEMP:     max_temp_ff     <= csr_wdata[15:0];
            tcc_pkg::CSR_COOLING_TEMP: cooling_temp_ff <= csr_wdata[15:0];
            tcc_pkg::CSR_RUN_SPEED:    run_speed_ff    <= csr_wdata[7:0];
            tcc_pkg::CSR_MANUAL_MASK:  manual_mask_ff  <= csr_wdata[4:0];
            tcc_pkg::CSR_START_PERIOD: start_period_ff <= csr_wdata;
            tcc_pkg::CSR_HEAT_ON:      heat_on_ff      <= csr_wdata;
            tcc_pkg::CSR_HEAT_OFF:     heat_off_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // sensors beyond the populated count repeat sensor 1 (no effect on max)
   always_comb begin
      temps[0] = req_temp_1;
      temps[1] = req_temp_2;
      temps[2] = req_temp_3;
      temps[3] = req_temp_4;
      temps[4] = req_temp_5;
      temps[5] = req_temp_6;
      temps[6] = req_temp_7;
      temps[7] = req_temp_8;
      temps[8] = req_temp_9;
      temps[9] = req_temp_10;
      for (int i = 1; i < tcc_pkg::MAX_SENSORS; i++) begin
         if (i >= tcc_pkg::NUM_SENSORS) begin
            temps[i] = req_temp_1;
         end
      end
   end

   // signed maximum tree, four compare levels
   always_comb begin
      for (int i = 0; i < 5; i++) begin
         lvl1[i] = tcc_pkg::smax(temps[2*i], temps[2*i+1]);
      end
      lvl2a     = tcc_pkg::smax(lvl1[0], lvl1[1]);
      lvl2b     = tcc_pkg::smax(lvl1[2], lvl1[3]);
      lvl3      = tcc_pkg::smax(lvl2a, lvl2b);
      frame_max = tcc_pkg::smax(lvl3, lvl1[4]);
   end

   assign over_temp = frame_max > max_temp_ff;

   // saturating tick counters
   assign start_inc = (start_elapsed_ff == '1) ? start_elapsed_ff : start_elapsed_ff + 32'd1;
   assign phase_inc = (phase_elapsed_ff == '1) ? phase_elapsed_ff : phase_elapsed_ff + 32'd1;

   // next state for one item
   always_comb begin
      start_elapsed_in = start_elapsed_ff;
      phase_elapsed_in = phase_elapsed_ff;
      in_start_in      = in_start_ff;
      window_in        = window_ff;
      speed_in         = speed_ff;
      heater_in        = heater_ff;
      cooler_in        = cooler_ff;
      if (req_operation == tcc_pkg::OP_TICK) begin
         start_elapsed_in = start_inc;
         phase_elapsed_in = phase_inc;
         if (start_inc > start_period_ff) begin
            in_start_in = 1'b0;
            // window toggles when its own period is strictly exceeded
            if (window_ff) begin
               if (phase_inc > heat_on_ff) begin
                  window_in        = 1'b0;
                  phase_elapsed_in = '0;
               end
            end else begin
               if (phase_inc > heat_off_ff) begin
                  window_in        = 1'b1;
                  phase_elapsed_in = '0;
               end
            end
         end
      end else begin
         if (!manual_mask_ff[tcc_pkg::MAN_CONVEYOR_BIT]) begin
            speed_in = (in_start_ff || over_temp) ? 8'd0 : run_speed_ff;
         end
         for (int i = 0; i < tcc_pkg::NUM_HEATERS; i++) begin
            if (!manual_mask_ff[tcc_pkg::MAN_HEATER0_BIT + i]) begin
               heater_in[i] = window_ff && !over_temp;
            end
         end
         if (!manual_mask_ff[tcc_pkg::MAN_COOLER_BIT]) begin
            cooler_in = frame_max > cooling_temp_ff;
         end
      end
   end

   // state update on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         start_elapsed_ff <= '0;
         phase_elapsed_ff <= '0;
         in_start_ff      <= 1'b1;
         window_ff        <= 1'b1;
         speed_ff         <= '0;
         heater_ff        <= '0;
         cooler_ff        <= 1'b0;
      end else if (accept) begin
         start_elapsed_ff <= start_elapsed_in;
         phase_elapsed_ff <= phase_elapsed_in;
         in_start_ff      <= in_start_in;
         window_ff        <= window_in;
         speed_ff         <= speed_in;
         heater_ff        <= heater_in;
         cooler_ff        <= cooler_in;
      end
   end

   // result valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result payload snapshot
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_speed_ff  <= speed_in;
         rsp_heater_ff <= heater_in;
         rsp_cooler_ff <= cooler_in;
         rsp_window_ff <= window_in;
         rsp_start_ff  <= in_start_in;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_conveyor_speed_out = rsp_speed_ff;
   assign rsp_heater_bits        = rsp_heater_ff;
   assign rsp_cooler_on          = rsp_cooler_ff;
   assign rsp_heating_window_on  = rsp_window_ff;
   assign rsp_start_phase_on     = rsp_start_ff;

endmodule
